// ===== rtl/assert_macros.svh =====
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// next-cycle implication
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

// condition never holds
`define CHK_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("check failed: forbidden condition");

`endif

// ===== rtl/b2da_pkg.sv =====
package b2da_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int DIGIT_W         = 4;
  localparam int CHAR_W          = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // decimal digits needed for w bits: floor(w * log10(2)) + 1
  function automatic int num_digits(input int w);
    return ((w * 1233) >> 12) + 1;
  endfunction

  typedef struct packed {
    logic load;
    logic dabble;
    logic shift_digit;
  } b2da_cmd_t;

  typedef struct packed {
    logic top_zero;
  } b2da_sts_t;

endpackage

// ===== rtl/binary_to_decimal_ascii_unit.sv =====
// channel | ports                                  | word
// --------+----------------------------------------+------------------------------
// input   | in_valid, in_ready, in_value           | one binary value
// output  | out_valid, out_ready, out_digit_char,  | one ascii digit, msd first,
//         | out_last_digit                         | last_digit set on the lsd
//
// one value at a time: a load, then VALUE_WIDTH double dabble steps (shift and
// add-3 per bit), a step per leading zero dropped (at least one digit is kept),
// a step to start emitting, then one digit per cycle while out_ready is high;
// dropped zeros plus digits always make NUM_DIGITS
// output stalls hold the current digit and the whole sequencer
// synchronous active-low reset returns the controller to idle
module binary_to_decimal_ascii_unit #(
  parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [VALUE_WIDTH-1:0]      in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [b2da_pkg::CHAR_W-1:0] out_digit_char,
  output logic                        out_last_digit
);
  import b2da_pkg::*;

  localparam int NUM_DIGITS = num_digits(VALUE_WIDTH);

  b2da_cmd_t cmd;
  b2da_sts_t sts;

  b2da_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_last_digit (out_last_digit),
    .cmd            (cmd),
    .sts            (sts)
  );

  b2da_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_dp (
    .clk            (clk),
    .in_value       (in_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_digit_char (out_digit_char)
  );

endmodule

// ===== rtl/b2da_datapath.sv =====
module b2da_datapath #(
  parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF,
  parameter int NUM_DIGITS  = b2da_pkg::num_digits(b2da_pkg::VALUE_WIDTH_DEF)
) (
  input  logic                           clk,
  input  logic [VALUE_WIDTH-1:0]         in_value,
  input  b2da_pkg::b2da_cmd_t            cmd,
  output b2da_pkg::b2da_sts_t            sts,
  output logic [b2da_pkg::CHAR_W-1:0]    out_digit_char
);
  import b2da_pkg::*;

  localparam int BCD_W = DIGIT_W * NUM_DIGITS;

  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [BCD_W-1:0]       bcd_adj;
  logic [DIGIT_W-1:0]     top_digit;

  // add 3 to every digit of five or more
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (cmd.load) begin
      bin_nxt = in_value;
      bcd_nxt = '0;
    end else if (cmd.dabble) begin
      bin_nxt = {bin_r[VALUE_WIDTH-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VALUE_WIDTH-1]};
    end else if (cmd.shift_digit) begin
      bcd_nxt = {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit      = bcd_r[BCD_W-1 -: DIGIT_W];
  assign sts.top_zero   = (top_digit == '0);
  assign out_digit_char = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};

endmodule

// ===== rtl/b2da_ctrl.sv =====
module b2da_ctrl #(
  parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF,
  parameter int NUM_DIGITS  = b2da_pkg::num_digits(b2da_pkg::VALUE_WIDTH_DEF)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_last_digit,
  output b2da_pkg::b2da_cmd_t cmd,
  input  b2da_pkg::b2da_sts_t sts
);
  import b2da_pkg::*;

  localparam int BW = $clog2(VALUE_WIDTH + 1);
  localparam int RW = $clog2(NUM_DIGITS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SKIP, ST_EMIT} state_t;

  state_t        state_r, state_nxt;
  logic [BW-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [RW-1:0] rem_r, rem_nxt;

  always_comb begin
    state_nxt   = state_r;
    bit_cnt_nxt = bit_cnt_r;
    rem_nxt     = rem_r;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          bit_cnt_nxt = BW'(VALUE_WIDTH);
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.dabble  = 1'b1;
        bit_cnt_nxt = bit_cnt_r - BW'(1);
        if (bit_cnt_r == BW'(1)) begin
          rem_nxt   = RW'(NUM_DIGITS);
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (sts.top_zero && rem_r != RW'(1)) begin
          cmd.shift_digit = 1'b1;
          rem_nxt         = rem_r - RW'(1);
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          cmd.shift_digit = 1'b1;
          rem_nxt         = rem_r - RW'(1);
          if (rem_r == RW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bit_cnt_r <= '0;
      rem_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      rem_r     <= rem_nxt;
    end
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = (state_r == ST_EMIT);
  assign out_last_digit = (rem_r == RW'(1));

endmodule

// ===== rtl/b2da_checker.sv =====
`include "assert_macros.svh"

module b2da_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [b2da_pkg::CHAR_W-1:0] out_digit_char,
  input logic                        out_last_digit
);
  import b2da_pkg::*;

  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_digit_char) && $stable(out_last_digit))
  `CHK_NEVER(a_busy_excl, clk, rst_n, in_ready && out_valid)
  `CHK_IMPLY(a_digit_range, clk, rst_n, out_valid, out_digit_char >= ASCII_ZERO && out_digit_char <= ASCII_ZERO + 6'd9)
  `CHK_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind binary_to_decimal_ascii_unit b2da_checker u_b2da_checker (.*);
